/* rtl/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

	localparam int VALUE_W = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage
`default_nettype wire

/* rtl/dq_ram.sv */
// Single-port entry store with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dq_ram
	import dq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic               re,
	input  wire logic [AW-1:0]      addr,
	input  wire logic [VALUE_W-1:0] wdata,
	output logic      [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/double_ended_queue.sv */
// Top level of the bounded double-ended queue of 32-bit signed values.
// Usage:
//   Commands enter on the s_axis channel: tuser carries the command code
//   (push front, push back, pop front, pop back, peek front, peek back) and
//   tdata the value to push. Each command gives exactly one result
//   transaction on the m_axis channel: value, status, empty flag, fill count.
//   From command acceptance to result valid, the entry store is read or
//   written at the acceptance edge, the read word lands in stage one, and the
//   result register follows. A command can be accepted every cycle while the
//   receiver does not stall; a push is written at its own acceptance edge, so
//   a command that follows it reads the new entry with no bubble.
//   Pop or peek on an empty queue reports status empty, push on a full queue
//   reports status full; neither changes the queue. Codes 6 and 7 do nothing
//   and report status ok.
//   Reset clears the indices, the count and the valid flags; stored entries
//   are not cleared and are never read before being written.
//   When the receiver stalls, the result register holds, stage one holds
//   behind it, and s_axis_tready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [VALUE_W-1:0] s_axis_tdata,  // [31:0] push_value
	input  wire logic [CMD_W-1:0]   s_axis_tuser,  // [2:0] command
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// [31:0] out_value, [33:32] status, [34] is_empty, [39:35] fill_count
	output logic [39:0]             m_axis_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;

	logic          s1_valid_q;
	logic          rd_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;

	logic          out_valid_q;
	logic [39:0]   out_data_q;

	logic          accept, s1_adv;
	cmd_t          cmd;
	logic          full, empty;
	logic [AW-1:0] front_prev, front_next, back_prev, back_next;
	logic [AW-1:0] front_d, back_d, addr;
	logic [CW-1:0] count_d;
	logic          we, re;
	status_t       status_d;
	logic [VALUE_W-1:0] rdata;
	logic [VALUE_W-1:0] value_s1;
	logic [CW+FILL_W-1:0] count_ext;

	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);
	assign full          = (count_q == FULL_CNT);
	assign empty         = (count_q == '0);

	assign front_prev = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_next = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		addr     = front_q;
		we       = 1'b0;
		re       = 1'b0;
		status_d = ST_OK;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d = front_prev;
					addr    = front_prev;
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					back_d  = back_next;
					addr    = back_q;
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = front_next;
					addr    = front_q;
					re      = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					back_d  = back_prev;
					addr    = back_prev;
					re      = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_PEEK_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					addr = front_q;
					re   = 1'b1;
				end
			end
			CMD_PEEK_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					addr = back_prev;
					re   = 1'b1;
				end
			end
			default: begin
				// unused codes leave the queue alone
			end
		endcase
	end

	dq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (accept && we),
		.re    (accept && re),
		.addr  (addr),
		.wdata (s_axis_tdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= re;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	assign value_s1  = rd_s1 ? rdata : '0;
	assign count_ext = {{FILL_W{1'b0}}, count_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {count_ext[FILL_W-1:0], (count_s1 == '0), status_s1, value_s1};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	// empty or full ring has coinciding indices
	a_ring_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL_CNT) |-> (front_q == back_q))
		else $error("indices disagree with count");

	// rejected push leaves the queue untouched
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
		|=> ($stable(count_q) && $stable(front_q) && $stable(back_q)))
		else $error("push on full queue changed state");

	// successful pop drops the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK))
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not decrement count");

	// stage one never overwritten while it waits
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("stage one overrun");

endmodule
`default_nettype wire
